// ===== design/addressable_led_serializer_unit_macros.svh =====
// Assertion macros shared by the addressable LED serializer RTL.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ADDRESSABLE_LED_SERIALIZER_UNIT_MACROS_SVH
`define ADDRESSABLE_LED_SERIALIZER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ALSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ALSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/alsu_pkg.sv =====
// Package for the addressable LED serializer: sizes, reset values, codes and types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package alsu_pkg;

    localparam int NUM_LEDS    = 4;
    localparam int MASK_W      = 4;
    localparam int COLOUR_W    = 24;
    localparam int TOTAL_BITS  = NUM_LEDS * COLOUR_W;
    localparam int BITS_W      = $clog2(TOTAL_BITS + 1);
    localparam int SET_LEDS    = (NUM_LEDS < MASK_W) ? NUM_LEDS : MASK_W;
    localparam int TIME_W      = 8;
    localparam int GAP_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = 1;
    localparam int FIFO_CNT_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 3'd4;

    localparam logic [TIME_W-1:0] RST_ONE_HIGH  = 8'd38;
    localparam logic [TIME_W-1:0] RST_ONE_LOW   = 8'd2;
    localparam logic [TIME_W-1:0] RST_ZERO_HIGH = 8'd14;
    localparam logic [TIME_W-1:0] RST_ZERO_LOW  = 8'd20;
    localparam logic [GAP_W-1:0]  RST_GAP       = 16'd3200;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_SET,
        OP_START,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_GAP_PRE,
        PH_HIGH,
        PH_LOW,
        PH_GAP_POST
    } t_phase;

    typedef struct packed {
        t_op                 op;
        logic [MASK_W-1:0]   mask;
        logic [COLOUR_W-1:0] rgb;
    } t_item;

    function automatic logic [COLOUR_W-1:0] f_reset_colour(input int idx);
        logic [COLOUR_W-1:0] c;
        case (idx)
            0:       c = 24'h2000FF;
            1:       c = 24'hFF0000;
            2:       c = 24'h00FF00;
            3:       c = 24'h0000FF;
            default: c = '0;
        endcase
        return c;
    endfunction

    // RRGGBB to the wire order GGRRBB.
    function automatic logic [COLOUR_W-1:0] f_grb(input logic [COLOUR_W-1:0] c);
        return {c[15:8], c[23:16], c[7:0]};
    endfunction

    function automatic logic [GAP_W-1:0] f_at_least_one(input logic [TIME_W-1:0] v);
        logic [TIME_W-1:0] t;
        t = (v == '0) ? TIME_W'(1) : v;
        return GAP_W'(t);
    endfunction

endpackage

// ===== design/alsu_front.sv =====
// Front end of the LED serializer: input transaction register and command decode.
// Depends on alsu_pkg; feeds alsu_fifo.
`timescale 1ns / 1ps

module alsu_front import alsu_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_cmd,
    input  logic [MASK_W-1:0]   i_led_mask,
    input  logic [COLOUR_W-1:0] i_rgb_value,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output t_item               o_push_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item.mask = i_led_mask;
        n_item.rgb  = i_rgb_value;
        case (i_cmd)
            CMD_TICK:  n_item.op = OP_TICK;
            CMD_SET:   n_item.op = OP_SET;
            CMD_START: n_item.op = OP_START;
            default:   n_item.op = OP_NOP;
        endcase
    end

    assign o_in_ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== design/alsu_fifo.sv =====
// Short queue of decoded items between the front end and the waveform engine.
// Depends on alsu_pkg for the item type and depth.
`timescale 1ns / 1ps

module alsu_fifo import alsu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_item
);

    t_item                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  push;
    logic                  pop;

    assign o_push_ready = (r_count != FIFO_CNT_W'(FIFO_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ===== design/alsu_back.sv =====
// Waveform engine of the LED serializer: colour store, timing registers,
// phase sequencer and output register. Depends on alsu_pkg and the macro header.
`timescale 1ns / 1ps
`include "addressable_led_serializer_unit_macros.svh"

module alsu_back import alsu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_pop_valid,
    output logic                  o_pop_ready,
    input  t_item                 i_pop_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_line,
    output logic                  o_busy_res
);

    logic [TIME_W-1:0]     r_one_high;
    logic [TIME_W-1:0]     r_one_low;
    logic [TIME_W-1:0]     r_zero_high;
    logic [TIME_W-1:0]     r_zero_low;
    logic [GAP_W-1:0]      r_gap;

    logic [COLOUR_W-1:0]   r_colours [NUM_LEDS];
    logic [COLOUR_W-1:0]   n_colours [NUM_LEDS];
    logic [TOTAL_BITS-1:0] r_shift;
    logic [TOTAL_BITS-1:0] n_shift;
    logic [TOTAL_BITS-1:0] snapshot;
    logic [BITS_W-1:0]     r_bits;
    logic [BITS_W-1:0]     n_bits;
    logic [BITS_W-1:0]     bits_dec;
    t_phase                r_phase;
    t_phase                n_phase;
    logic [GAP_W-1:0]      r_tick;
    logic [GAP_W-1:0]      n_tick;
    logic [GAP_W-1:0]      tick_dec;

    logic                  r_out_valid;
    logic                  r_line;
    logic                  r_busy;
    logic                  n_line;
    logic                  n_busy;
    logic                  pop;

    assign o_pop_ready = !r_out_valid || i_out_ready;
    assign pop         = i_pop_valid && o_pop_ready;
    assign o_out_valid = r_out_valid;
    assign o_line      = r_line;
    assign o_busy_res  = r_busy;

    // LED 0 occupies the top bits so the frame shifts out from the MSB.
    always_comb begin
        snapshot = '0;
        for (int i = 0; i < NUM_LEDS; i++) begin
            snapshot[TOTAL_BITS-1-COLOUR_W*i -: COLOUR_W] = f_grb(r_colours[i]);
        end
    end

    assign tick_dec = (r_tick != '0) ? r_tick - 1'b1 : '0;
    assign bits_dec = (r_bits != '0) ? r_bits - 1'b1 : '0;

    // Next state of the sequencer and the colour store for the popped item.
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bits  = r_bits;
        n_shift = r_shift;
        for (int i = 0; i < NUM_LEDS; i++) begin
            n_colours[i] = r_colours[i];
        end
        case (i_pop_item.op)
            OP_SET: begin
                for (int i = 0; i < SET_LEDS; i++) begin
                    if (i_pop_item.mask[i]) begin
                        n_colours[i] = i_pop_item.rgb;
                    end
                end
            end
            OP_START: begin
                if (r_phase == PH_IDLE) begin
                    n_shift = snapshot;
                    n_bits  = BITS_W'(TOTAL_BITS);
                    if (r_gap == '0) begin
                        n_phase = PH_HIGH;
                        n_tick  = f_at_least_one(snapshot[TOTAL_BITS-1] ? r_one_high
                                                                         : r_zero_high);
                    end else begin
                        n_phase = PH_GAP_PRE;
                        n_tick  = r_gap;
                    end
                end
            end
            OP_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_tick = tick_dec;
                    if (tick_dec == '0) begin
                        case (r_phase)
                            PH_GAP_PRE: begin
                                n_phase = PH_HIGH;
                                n_tick  = f_at_least_one(r_shift[TOTAL_BITS-1] ? r_one_high
                                                                                : r_zero_high);
                            end
                            PH_HIGH: begin
                                n_phase = PH_LOW;
                                n_tick  = f_at_least_one(r_shift[TOTAL_BITS-1] ? r_one_low
                                                                                : r_zero_low);
                            end
                            PH_LOW: begin
                                n_bits = bits_dec;
                                if (bits_dec != '0) begin
                                    n_shift = {r_shift[TOTAL_BITS-2:0], 1'b0};
                                    n_phase = PH_HIGH;
                                    n_tick  = f_at_least_one(r_shift[TOTAL_BITS-2]
                                                             ? r_one_high : r_zero_high);
                                end else if (r_gap == '0) begin
                                    n_phase = PH_IDLE;
                                    n_tick  = '0;
                                end else begin
                                    n_phase = PH_GAP_POST;
                                    n_tick  = r_gap;
                                end
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                n_tick  = '0;
                            end
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result fields follow the phase after this transaction.
    always_comb begin
        n_line = (n_phase == PH_HIGH);
        n_busy = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_high  <= RST_ONE_HIGH;
            r_one_low   <= RST_ONE_LOW;
            r_zero_high <= RST_ZERO_HIGH;
            r_zero_low  <= RST_ZERO_LOW;
            r_gap       <= RST_GAP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ONE_HIGH:  r_one_high  <= i_cfg_data[TIME_W-1:0];
                CFG_ONE_LOW:   r_one_low   <= i_cfg_data[TIME_W-1:0];
                CFG_ZERO_HIGH: r_zero_high <= i_cfg_data[TIME_W-1:0];
                CFG_ZERO_LOW:  r_zero_low  <= i_cfg_data[TIME_W-1:0];
                CFG_GAP:       r_gap       <= i_cfg_data[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bits      <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
            r_line      <= 1'b0;
            r_busy      <= 1'b0;
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_colours[i] <= f_reset_colour(i);
            end
        end else begin
            if (o_pop_ready) begin
                r_out_valid <= i_pop_valid;
            end
            if (pop) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_bits  <= n_bits;
                r_shift <= n_shift;
                r_line  <= n_line;
                r_busy  <= n_busy;
                for (int i = 0; i < NUM_LEDS; i++) begin
                    r_colours[i] <= n_colours[i];
                end
            end
        end
    end

    `ALSU_ASSERT_NOW(a_line_needs_busy, r_out_valid && r_line, r_busy, "line high while not busy")
    `ALSU_ASSERT_NOW(a_idle_no_ticks, r_phase == PH_IDLE, r_tick == '0, "idle with ticks left")
    `ALSU_ASSERT_NOW(a_bit_has_bits, r_phase == PH_HIGH || r_phase == PH_LOW, r_bits != '0,
        "bit phase with no bits left")
    `ALSU_ASSERT_NEXT(a_idle_tick_stays, pop && r_phase == PH_IDLE && i_pop_item.op == OP_TICK,
        r_phase == PH_IDLE, "tick left idle state")

endmodule

// ===== design/addressable_led_serializer_unit.sv =====
// Addressable LED serializer: single-wire RGB LED chain driver.
//
// Channels: the input channel (i_in_valid / o_in_ready) carries i_cmd, i_led_mask and
// i_rgb_value; cmd 0 is a tick, 1 sets the colours of masked LEDs, 2 starts a frame.
// Every input transaction yields exactly one result transaction on the output channel
// (o_out_valid / i_out_ready) with o_line, the data line level, and o_busy_res.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the bit timing and gap
// registers by index; it is always ready. It is to be written only while no transaction
// is in flight: the user is bound to this and the block does not enforce it. New timing
// takes effect at the next phase of the frame. An accepted input transaction passes the
// front register, a queue entry and then the output register, which holds its result.
// Throughput, while the receiver does not stall: one transaction per cycle; the waveform
// engine retires one item per cycle. When the receiver stalls, the output register holds
// and the two-entry queue and front register absorb up to three more transactions
// before o_in_ready drops. Reset (synchronous, active low) restores the default colours
// and timing, empties the queue and the output register, and leaves the line idle.
// Depends on alsu_pkg, alsu_front, alsu_fifo and alsu_back.
`timescale 1ns / 1ps

module addressable_led_serializer_unit import alsu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_cmd,
    input  logic [MASK_W-1:0]     i_led_mask,
    input  logic [COLOUR_W-1:0]   i_rgb_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_line,
    output logic                  o_busy_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic  push_valid;
    logic  push_ready;
    t_item push_item;
    logic  pop_valid;
    logic  pop_ready;
    t_item pop_item;

    assign o_cfg_ready = 1'b1;

    alsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_led_mask   (i_led_mask),
        .i_rgb_value  (i_rgb_value),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    alsu_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    alsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_item  (pop_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_line      (o_line),
        .o_busy_res  (o_busy_res)
    );

endmodule
